[design/rpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types, constants and helpers of the run-length packet decoder.
// ----------------------------------------------------------------------------
package rpd_pkg;

    localparam int SIZE_W     = 4;   // effective element size, 1..MAX_ELEMENT_BYTES
    localparam int TOTAL_W    = 17;  // element_count * element_size
    localparam int CMP_W      = 18;  // room for position plus one run
    localparam int REM_W      = 11;  // remaining bytes when a run is clipped
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = 1;

    localparam logic [7:0] HDR_TYPE_MASK = 8'h80;
    localparam logic [7:0] HDR_LEN_MASK  = 8'h7f;

    localparam logic [0:0] REG_ELEMENT_SIZE  = 1'b0;
    localparam logic [0:0] REG_ELEMENT_COUNT = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_REPEAT = 2'd1,
        PH_RAW    = 2'd2
    } rpd_phase_t;

    // One finished element run travelling from the front to the back.
    typedef struct packed {
        logic [31:0]        value;
        logic [7:0]         run_raw;
        logic [15:0]        position;
        logic [SIZE_W-1:0]  size;
        logic [REM_W-1:0]   rem_bytes;
        logic               clip;
        logic               last;
    } rpd_rec_t;

    // ceil(rem / size) for small remainders; sizes that are not powers of two use a reciprocal.
    function automatic logic [7:0] rpd_ceil_div(input logic [REM_W-1:0] rem,
                                                 input logic [SIZE_W-1:0] size);
        logic [REM_W-1:0] x;
        logic [REM_W+15:0] prod;
        logic [REM_W-1:0] q;
        x    = rem + REM_W'(size) - REM_W'(1);
        prod = '0;
        case (size)
            4'd2: q = x >> 1;
            4'd4: q = x >> 2;
            4'd8: q = x >> 3;
            4'd3: begin
                prod = x * 16'd21846;
                q    = prod[REM_W+15:16];
            end
            4'd5: begin
                prod = x * 16'd13108;
                q    = prod[REM_W+15:16];
            end
            4'd6: begin
                prod = x * 16'd10923;
                q    = prod[REM_W+15:16];
            end
            4'd7: begin
                prod = x * 16'd9363;
                q    = prod[REM_W+15:16];
            end
            default: q = x;
        endcase
        return q[7:0];
    endfunction

endpackage

[design/rle_packet_decoder_top.sv]
`timescale 1ns / 1ps
// A result item is written to a queue entry and then to the output register after the last
// byte of its element is accepted. Throughput: one compressed byte per cycle while the
// two-entry queue is not full; the output register takes the next item once it is empty or accepted.
// Reset: aresetn is synchronous and active low; it clears the parse state, the position,
// the queue and the output valid, and sets element_size and element_count to 1.
// ----------------------------------------------------------------------------
// rle_packet_decoder_top
// Run-length packet decoder with an APB-style configuration port.
// ----------------------------------------------------------------------------
module rle_packet_decoder_top import rpd_pkg::*; #(
    parameter int MAX_ELEMENT_BYTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // element_value[31:0], repeat_count[39:32], position[55:40]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0]          size_reg, size_next;
    logic [13:0]         count_reg, count_next;
    logic [SIZE_W-1:0]   eff_size_reg, eff_size_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;

    logic [SIZE_W-1:0]   wr_size;
    logic [13:0]         wr_count;
    logic                cfg_write;

    logic                q_full;
    logic                q_empty;
    logic                q_push;
    logic                q_pop;
    rpd_rec_t            push_rec;
    rpd_rec_t            pop_rec;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_ELEMENT_COUNT) ? {18'd0, count_reg} :
                                                         {29'd0, size_reg};

    // Out-of-range sizes and a zero count act as the nearest legal value.
    always_comb begin
        wr_size = SIZE_W'(pwdata[2:0]);
        if (wr_size == '0) begin
            wr_size = SIZE_W'(1);
        end
        if (wr_size > SIZE_W'(MAX_ELEMENT_BYTES)) begin
            wr_size = SIZE_W'(MAX_ELEMENT_BYTES);
        end
        wr_count = (pwdata[13:0] == 14'd0) ? 14'd1 : pwdata[13:0];

        size_next     = size_reg;
        count_next    = count_reg;
        eff_size_next = eff_size_reg;
        total_next    = total_reg;
        if (cfg_write) begin
            if (paddr[2] == REG_ELEMENT_SIZE) begin
                size_next     = pwdata[2:0];
                eff_size_next = wr_size;
                total_next    = TOTAL_W'((count_reg == 14'd0) ? 14'd1 : count_reg) *
                                TOTAL_W'(wr_size);
            end else begin
                count_next = pwdata[13:0];
                total_next = TOTAL_W'(wr_count) * TOTAL_W'(eff_size_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= 3'd1;
            count_reg    <= 14'd1;
            eff_size_reg <= SIZE_W'(1);
            total_reg    <= TOTAL_W'(1);
        end else begin
            size_reg     <= size_next;
            count_reg    <= count_next;
            eff_size_reg <= eff_size_next;
            total_reg    <= total_next;
        end
    end

    rpd_front #(
        .MAX_ELEMENT_BYTES(MAX_ELEMENT_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .q_full   (q_full),
        .eff_size (eff_size_reg),
        .total    (total_reg),
        .in_ready (s_tready),
        .q_push   (q_push),
        .q_rec    (push_rec)
    );

    rpd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .pop_rec  (pop_rec),
        .full     (q_full),
        .empty    (q_empty)
    );

    rpd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rec    (pop_rec),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[design/rpd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_front
// Parses headers, assembles element bytes and tracks the output position.
// ----------------------------------------------------------------------------
module rpd_front import rpd_pkg::*; #(
    parameter int MAX_ELEMENT_BYTES = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                q_full,
    input  logic [SIZE_W-1:0]   eff_size,
    input  logic [TOTAL_W-1:0]  total,
    output logic                in_ready,
    output logic                q_push,
    output rpd_rec_t            q_rec
);

    localparam int BUF_W = 8 * MAX_ELEMENT_BYTES;
    localparam int IW    = (MAX_ELEMENT_BYTES > 1) ? $clog2(MAX_ELEMENT_BYTES) : 1;

    rpd_phase_t       phase_reg, phase_next;
    logic [7:0]       remain_reg, remain_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [BUF_W-1:0] buf_reg, buf_next;
    logic [15:0]      pos_reg, pos_next;

    logic [BUF_W-1:0]     buf_fill;
    logic [7:0]           run_raw;
    logic [11:0]          run_bytes;
    logic [11:0]          prev_bytes;
    logic [CMP_W-1:0]     end_pos;
    logic [CMP_W-1:0]     rem_bytes;
    logic                 done;
    logic                 clip;
    logic                 elem_done;
    logic                 accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            remain_reg <= '0;
            idx_reg    <= '0;
            buf_reg    <= '0;
            pos_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            idx_reg    <= idx_next;
            buf_reg    <= buf_next;
            pos_reg    <= pos_next;
        end
    end

    always_comb begin
        buf_fill = buf_reg;
        for (int i = 0; i < MAX_ELEMENT_BYTES; i++) begin
            if (idx_reg == IW'(i)) begin
                buf_fill[8*i +: 8] = in_byte;
            end
        end
    end

    assign elem_done  = (SIZE_W'(idx_reg) + SIZE_W'(1)) >= eff_size;
    assign run_raw    = (phase_reg == PH_REPEAT) ?
                        ((remain_reg == 8'd0) ? 8'd1 : remain_reg) : 8'd1;
    assign run_bytes  = run_raw * 12'(eff_size);
    assign prev_bytes = run_bytes - 12'(eff_size);
    assign end_pos    = CMP_W'(pos_reg) + CMP_W'(run_bytes);
    assign rem_bytes  = (CMP_W'(total) > CMP_W'(pos_reg)) ?
                        CMP_W'(total) - CMP_W'(pos_reg) : '0;
    assign done       = end_pos >= CMP_W'(total);
    // A repeat run longer than what the image still needs gets clipped later.
    assign clip       = CMP_W'(prev_bytes) >= rem_bytes;

    always_comb begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        idx_next    = idx_reg;
        buf_next    = buf_reg;
        pos_next    = pos_reg;
        q_push      = 1'b0;

        q_rec.value     = 32'(buf_fill);
        q_rec.run_raw   = run_raw;
        q_rec.position  = pos_reg;
        q_rec.size      = eff_size;
        q_rec.rem_bytes = rem_bytes[REM_W-1:0];
        q_rec.clip      = clip;
        q_rec.last      = done;

        if (accept) begin
            case (phase_reg)
                PH_REPEAT, PH_RAW: begin
                    if (!elem_done) begin
                        buf_next = buf_fill;
                        idx_next = idx_reg + IW'(1);
                    end else begin
                        q_push   = 1'b1;
                        buf_next = '0;
                        idx_next = '0;
                        if (done) begin
                            phase_next  = PH_HEADER;
                            remain_next = '0;
                            pos_next    = '0;
                        end else begin
                            pos_next = end_pos[15:0];
                            if (phase_reg == PH_REPEAT) begin
                                phase_next  = PH_HEADER;
                                remain_next = '0;
                            end else begin
                                remain_next = (remain_reg == 8'd0) ? 8'd0 :
                                              remain_reg - 8'd1;
                                if (remain_next == 8'd0) begin
                                    phase_next = PH_HEADER;
                                end
                            end
                        end
                    end
                end
                default: begin
                    remain_next = (in_byte & HDR_LEN_MASK) + 8'd1;
                    phase_next  = ((in_byte & HDR_TYPE_MASK) != 8'd0) ? PH_REPEAT : PH_RAW;
                    idx_next    = '0;
                    buf_next    = '0;
                end
            endcase
        end
    end

endmodule

[design/rpd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_queue
// Two-entry queue of element runs between the front and the back.
// ----------------------------------------------------------------------------
module rpd_queue import rpd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  rpd_rec_t push_rec,
    input  logic     pop,
    output rpd_rec_t pop_rec,
    output logic     full,
    output logic     empty
);

    rpd_rec_t         mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]    count_reg, count_next;

    assign full    = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_rec = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = wr_ptr_reg + Q_AW'(1);
        end
        if (pop && !empty) begin
            rd_ptr_next = rd_ptr_reg + Q_AW'(1);
        end
        if ((push && !full) && !(pop && !empty)) begin
            count_next = count_reg + (Q_AW+1)'(1);
        end else if (!(push && !full) && (pop && !empty)) begin
            count_next = count_reg - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

[design/rpd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_back
// Clips repeat runs to the remaining image and holds the result register.
// ----------------------------------------------------------------------------
module rpd_back import rpd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  rpd_rec_t    q_rec,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic        m_tlast
);

    logic        valid_reg, valid_next;
    logic [55:0] data_reg, data_next;
    logic        last_reg, last_next;
    logic [7:0]  rem_el;
    logic [7:0]  run;

    // A clipped run covers the rest of the image in whole elements, with at least one element.
    assign rem_el = rpd_ceil_div(q_rec.rem_bytes, q_rec.size);
    assign run    = !q_rec.clip ? q_rec.run_raw :
                    (rem_el == 8'd0) ? 8'd1 : rem_el;

    assign q_pop = !q_empty && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (q_pop) begin
            valid_next = 1'b1;
            data_next  = {q_rec.position, run, q_rec.value};
            last_next  = q_rec.last;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

[test/rle_packet_decoder_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_packet_decoder_top_test
// Self-checking bench for the run-length packet decoder. Compressed bytes are
// streamed in with random gaps while the result side stalls at random. A
// scoreboard decodes every accepted byte on its own copy of the registers and
// state, then checks each element run that leaves the block. The element size
// and count registers are rewritten between phases, including mid-packet.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [31:0] value;
    logic [7:0]  count;
    logic [15:0] pos;
    logic        last;
} element_run_t;

class run_scoreboard;
    rpd_pkg::rpd_phase_t phase;
    logic [7:0]   pkt_left;
    int unsigned  byte_idx;
    logic [63:0]  assembly;
    logic [15:0]  out_pos;
    logic [2:0]   reg_size;
    logic [13:0]  reg_count;
    int unsigned  max_bytes;
    element_run_t pending_runs[$];
    int           errors;

    function new(int unsigned max_el_bytes);
        max_bytes = max_el_bytes;
        reg_size  = 3'd1;
        reg_count = 14'd1;
        errors    = 0;
        rearm();
    endfunction

    function void rearm();
        phase    = rpd_pkg::PH_HEADER;
        pkt_left = '0;
        byte_idx = 0;
        assembly = '0;
        out_pos  = '0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [31:0] value);
        if (idx == rpd_pkg::REG_ELEMENT_SIZE) begin
            reg_size = value[2:0];
        end else begin
            reg_count = value[13:0];
        end
    endfunction

    // Decode one accepted byte and queue the run it completes, if any.
    function void decode_byte(logic [7:0] b);
        int unsigned  size, total, rem_bytes, rem_el, run, run_end;
        element_run_t r;
        size = (reg_size == 0) ? 1 : ((reg_size > max_bytes) ? max_bytes : reg_size);
        total = ((reg_count == 0) ? 1 : int'(reg_count)) * size;
        if (phase != rpd_pkg::PH_REPEAT && phase != rpd_pkg::PH_RAW) begin
            pkt_left = (b & rpd_pkg::HDR_LEN_MASK) + 8'd1;
            phase    = ((b & rpd_pkg::HDR_TYPE_MASK) != 0) ? rpd_pkg::PH_REPEAT
                                                           : rpd_pkg::PH_RAW;
            byte_idx = 0;
            assembly = '0;
            return;
        end
        assembly |= 64'(b) << (8 * (byte_idx & 7));
        byte_idx++;
        if (byte_idx < size) return;

        if (phase == rpd_pkg::PH_REPEAT) begin
            // A repeat run is cut to the whole elements that the rest of the image still needs.
            rem_bytes = (total > out_pos) ? total - out_pos : 0;
            rem_el    = (rem_bytes + size - 1) / size;
            if (rem_el == 0) rem_el = 1;
            run = (pkt_left == 0) ? 1 : pkt_left;
            if (run > rem_el) run = rem_el;
            phase    = rpd_pkg::PH_HEADER;
            pkt_left = '0;
        end else begin
            run = 1;
            if (pkt_left > 0) pkt_left--;
            if (pkt_left == 0) phase = rpd_pkg::PH_HEADER;
        end
        run_end = out_pos + run * size;
        r.value = assembly[31:0];
        r.count = run[7:0];
        r.pos   = out_pos;
        r.last  = (run_end >= total);
        pending_runs.push_back(r);
        byte_idx = 0;
        assembly = '0;
        if (r.last) begin
            rearm();
        end else begin
            out_pos = run_end[15:0];
        end
    endfunction

    function void check_run(logic [55:0] data, logic last);
        element_run_t want, got;
        got = '{data[31:0], data[39:32], data[55:40], last};
        if (pending_runs.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("ERROR: unexpected run value=%h count=%0d pos=%0d last=%b",
                         got.value, got.count, got.pos, got.last);
            end
            return;
        end
        want = pending_runs.pop_front();
        if (got.value !== want.value || got.count !== want.count ||
            got.pos !== want.pos || got.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
                $display("ERROR: expected value=%h count=%0d pos=%0d last=%b, got value=%h count=%0d pos=%0d last=%b",
                         want.value, want.count, want.pos, want.last,
                         got.value, got.count, got.pos, got.last);
            end
        end
    endfunction
endclass

module rle_packet_decoder_top_test;
    import rpd_pkg::*;

    localparam int MAX_EL_BYTES = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 56;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // data_byte[7:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // element_value[31:0], repeat_count[39:32], position[55:40]
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    bit          steady = 1'b0;
    int unsigned cycles = 0;
    run_scoreboard sb = new(MAX_EL_BYTES);

    rle_packet_decoder_top #(.MAX_ELEMENT_BYTES(MAX_EL_BYTES)) dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 29);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_run(m_tdata, m_tlast);
    end

    task automatic send_byte(input logic [7:0] b);
        if (!steady && $urandom_range(0, 99) < 29) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 29);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.decode_byte(b);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_runs.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, value);
    endtask

    // Headers cause no result, so give the block its latency before writing.
    task automatic configure(input logic [2:0] size, input logic [13:0] count);
        hold_until_drained();
        repeat (4) @(posedge aclk);
        write_reg(REG_ELEMENT_SIZE, 32'(size));
        write_reg(REG_ELEMENT_COUNT, 32'(count));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int         sizes[PHASES];
        int         counts[PHASES];
        logic [7:0] b;
        sizes  = '{2, 3, 5, 1, 6, 0, 4, 7};
        counts = '{5, 1, $urandom_range(2, 40), 16383, 0, $urandom_range(1, 60), 3,
                   $urandom_range(100, 16383)};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // After reset the image is one byte, so every run closes it.
        send_byte(8'h80); send_byte(8'hff);
        send_byte(8'hff); send_byte(8'h00);

        configure(3'd4, 14'd16383);
        send_byte(8'h00);
        send_byte(8'h78); send_byte(8'h56); send_byte(8'h34); send_byte(8'h12);
        send_byte(8'hff);
        send_byte(8'hff); send_byte(8'hff); send_byte(8'hff); send_byte(8'hff);
        send_byte(8'h7f);
        send_byte(8'h01); send_byte(8'h02); send_byte(8'h03); send_byte(8'h04);

        // The raw packet is still open and the position is already past the
        // new one-byte image, so the next byte closes it.
        configure(3'd0, 14'd0);
        send_byte(8'haa);

        // Oversized element size acts as four bytes; six repeats clip to two.
        configure(3'd7, 14'd2);
        send_byte(8'h85);
        send_byte(8'h11); send_byte(8'h22); send_byte(8'h33); send_byte(8'h44);

        for (int p = 0; p < PHASES; p++) begin
            configure(3'(sizes[p]), 14'(counts[p]));
            steady = (p == 3);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 5 && i == PHASE_ITEMS / 2) hold_until_drained();
                if (sb.phase == PH_REPEAT || sb.phase == PH_RAW) begin
                    b = 8'($urandom_range(0, 255));
                end else begin
                    // Mostly short packets so that images end often.
                    b[7]   = 1'($urandom_range(0, 1));
                    b[6:0] = ($urandom_range(0, 99) < 70) ? 7'($urandom_range(0, 7))
                                                          : 7'($urandom_range(0, 127));
                end
                send_byte(b);
            end
        end
        steady = 1'b0;

        hold_until_drained();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
